### rtl/sph_pkg.sv
// Shared constants, codes and control types of the substitution pair histogram unit.
`default_nettype none

package sph_pkg;

    // Default sizes of the count store
    localparam int NUM_CLASSES_DEF  = 16;
    localparam int NUM_RESIDUES_DEF = 22;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Constraint slots carried per column and the most that may be compared
    localparam int SLOT_COUNT      = 4;
    localparam int MAX_CONSTRAINTS = 4;
    localparam int ACTIVE_LIMIT    = (MAX_CONSTRAINTS < SLOT_COUNT) ? MAX_CONSTRAINTS
                                                                    : SLOT_COUNT;

    // Beat widths
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 3;
    localparam int CFG_W       = 3;

    // Action codes
    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Outcome codes
    localparam logic [2:0] OC_GAP        = 3'd0;
    localparam logic [2:0] OC_CONSTRAINT = 3'd1;
    localparam logic [2:0] OC_NO_CLASS   = 3'd2;
    localparam logic [2:0] OC_ONE        = 3'd3;
    localparam logic [2:0] OC_BOTH       = 3'd4;
    localparam logic [2:0] OC_DONE       = 3'd5;

    // Address select for the counter store
    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_READ   = 2'd2;

    typedef struct packed {
        logic       capture;   // register the incoming beat
        logic       rd;        // read cell and class total at the selected address
        logic       wr;        // write back the incremented values
        logic [1:0] sel;       // address select
        logic       clr_step;  // zero one entry of the sweep
        logic       load_out;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       do_first;
        logic       do_second;
        logic       sweep_last;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/sph_ctrl.sv
// Controller state machine of the substitution pair histogram unit.
`default_nettype none

module sph_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  wire sph_pkg::t_sts i_sts,
    output sph_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_WR1   = 3'd3;
    localparam logic [2:0] S_RD2   = 3'd4;
    localparam logic [2:0] S_WR2   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_report;
    logic       n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        o_cmd    = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_report = 1'b0;
                    n_state  = r_report ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.action)
                    sph_pkg::ACT_COUNT: begin
                        if (i_sts.do_first) begin
                            o_cmd.rd  = 1'b1;
                            o_cmd.sel = sph_pkg::SEL_FIRST;
                            n_state   = S_WR1;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    sph_pkg::ACT_READ: begin
                        o_cmd.rd  = 1'b1;
                        o_cmd.sel = sph_pkg::SEL_READ;
                        n_state   = S_FIN;
                    end
                    sph_pkg::ACT_CLEAR: begin
                        n_report = 1'b1;
                        n_state  = S_CLEAR;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_WR1: begin
                o_cmd.wr  = 1'b1;
                o_cmd.sel = sph_pkg::SEL_FIRST;
                n_state   = i_sts.do_second ? S_RD2 : S_FIN;
            end
            S_RD2: begin
                o_cmd.rd  = 1'b1;
                o_cmd.sel = sph_pkg::SEL_SECOND;
                n_state   = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr  = 1'b1;
                o_cmd.sel = sph_pkg::SEL_SECOND;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

### rtl/sph_dpath.sv
// Datapath of the substitution pair histogram unit: beat register, decode, count store, result.
`default_nettype none

module sph_dpath #(
    parameter int NUM_CLASSES  = sph_pkg::NUM_CLASSES_DEF,
    parameter int NUM_RESIDUES = sph_pkg::NUM_RESIDUES_DEF,
    parameter int COUNT_WIDTH  = sph_pkg::COUNT_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire  [sph_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire  [sph_pkg::IN_TDATA_W-1:0]  i_in_data,
    input  wire  [sph_pkg::IN_TUSER_W-1:0]  i_in_user,
    input  wire sph_pkg::t_cmd              i_cmd,
    output sph_pkg::t_sts                   o_sts,
    input  wire                             i_out_ready,
    output logic                            o_out_valid,
    output logic [31:0]                     o_out_cell,
    output logic [31:0]                     o_out_total,
    output logic [2:0]                      o_out_outcome
);

    localparam int CELLS_PER_CLASS = NUM_RESIDUES * NUM_RESIDUES;
    localparam int CELL_DEPTH      = NUM_CLASSES * CELLS_PER_CLASS;
    localparam int AW              = $clog2(CELL_DEPTH);
    localparam int CLS_W           = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // Configuration
    logic [sph_pkg::CFG_W-1:0] r_cfg;

    // Captured beat
    logic [1:0]  r_action;
    logic [4:0]  r_a1;
    logic [4:0]  r_a2;
    logic [4:0]  r_e1;
    logic [4:0]  r_e2;
    logic [31:0] r_f1;
    logic [31:0] r_f2;
    logic [3:0]  r_fp;
    logic [3:0]  r_renv;
    logic [4:0]  r_rrow;
    logic [4:0]  r_rcol;

    // Count store
    logic [COUNT_WIDTH-1:0] r_cell_mem [CELL_DEPTH];
    logic [COUNT_WIDTH-1:0] r_class_mem [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] r_cell_q;
    logic [COUNT_WIDTH-1:0] r_tot_q;
    logic [AW-1:0]          r_sweep;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_cell;
    logic [31:0] r_out_total;
    logic [2:0]  r_out_outcome;

    logic [2:0]             w_nact;
    logic                   w_gap;
    logic                   w_mism;
    logic                   w_e1_ok;
    logic                   w_e2_ok;
    logic                   w_renv_ok;
    logic                   w_rc_ok;
    logic [2:0]             w_count_outcome;
    logic [CLS_W-1:0]       w_cls;
    logic [4:0]             w_row;
    logic [4:0]             w_col;
    logic [AW-1:0]          w_addr;
    logic [AW-1:0]          w_mem_addr;
    logic [CLS_W-1:0]       w_mem_cls;
    logic                   w_sweep_last;
    logic                   w_sweep_cls;
    logic [COUNT_WIDTH-1:0] w_cell_inc;
    logic [COUNT_WIDTH-1:0] w_tot_inc;
    logic [31:0]            w_cell32;
    logic [31:0]            w_tot32;
    logic                   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_in_user;
            r_a1     <= i_in_data[4:0];
            r_a2     <= i_in_data[9:5];
            r_e1     <= i_in_data[14:10];
            r_e2     <= i_in_data[19:15];
            r_f1     <= i_in_data[51:20];
            r_f2     <= i_in_data[83:52];
            r_fp     <= i_in_data[87:84];
            r_renv   <= i_in_data[91:88];
            r_rrow   <= i_in_data[96:92];
            r_rcol   <= i_in_data[101:97];
        end
    end

    // Column decode
    assign w_nact = (r_cfg > 3'(sph_pkg::ACTIVE_LIMIT)) ? 3'(sph_pkg::ACTIVE_LIMIT) : r_cfg;
    assign w_gap  = (6'(r_a1) >= 6'(NUM_RESIDUES)) || (6'(r_a2) >= 6'(NUM_RESIDUES));

    always_comb begin
        w_mism = 1'b0;
        for (int s = 0; s < sph_pkg::SLOT_COUNT; s++) begin
            if ((3'(s) < w_nact) && r_fp[s] && (r_f1[8*s +: 8] != r_f2[8*s +: 8])) begin
                w_mism = 1'b1;
            end
        end
    end

    assign w_e1_ok   = !r_e1[4] && (7'(r_e1[3:0]) < 7'(NUM_CLASSES));
    assign w_e2_ok   = !r_e2[4] && (7'(r_e2[3:0]) < 7'(NUM_CLASSES));
    assign w_renv_ok = 7'(r_renv) < 7'(NUM_CLASSES);
    assign w_rc_ok   = (6'(r_rrow) < 6'(NUM_RESIDUES)) && (6'(r_rcol) < 6'(NUM_RESIDUES));

    always_comb begin
        if (w_gap) begin
            w_count_outcome = sph_pkg::OC_GAP;
        end else if (w_mism) begin
            w_count_outcome = sph_pkg::OC_CONSTRAINT;
        end else if (!w_e1_ok) begin
            w_count_outcome = sph_pkg::OC_NO_CLASS;
        end else if (w_e2_ok) begin
            w_count_outcome = sph_pkg::OC_BOTH;
        end else begin
            w_count_outcome = sph_pkg::OC_ONE;
        end
    end

    // Store address: first pair writes (e1, a2, a1), second (e2, a1, a2)
    always_comb begin
        case (i_cmd.sel)
            sph_pkg::SEL_FIRST: begin
                w_cls = CLS_W'(r_e1[3:0]);
                w_row = r_a2;
                w_col = r_a1;
            end
            sph_pkg::SEL_SECOND: begin
                w_cls = CLS_W'(r_e2[3:0]);
                w_row = r_a1;
                w_col = r_a2;
            end
            default: begin
                w_cls = CLS_W'(r_renv);
                w_row = r_rrow;
                w_col = r_rcol;
            end
        endcase
    end

    assign w_addr = AW'(w_cls) * AW'(CELLS_PER_CLASS) + AW'(w_row) * AW'(NUM_RESIDUES)
                  + AW'(w_col);
    assign w_mem_addr   = i_cmd.clr_step ? r_sweep : w_addr;
    assign w_mem_cls    = i_cmd.clr_step ? CLS_W'(r_sweep) : w_cls;
    assign w_sweep_last = (r_sweep == AW'(CELL_DEPTH - 1));
    assign w_sweep_cls  = {1'b0, r_sweep} < (AW + 1)'(NUM_CLASSES);

    assign w_cell_inc = (&r_cell_q) ? r_cell_q : r_cell_q + COUNT_WIDTH'(1);
    assign w_tot_inc  = (&r_tot_q) ? r_tot_q : r_tot_q + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_cell_mem[w_mem_addr] <= '0;
            if (w_sweep_cls) begin
                r_class_mem[w_mem_cls] <= '0;
            end
        end else if (i_cmd.wr) begin
            r_cell_mem[w_mem_addr]  <= w_cell_inc;
            r_class_mem[w_mem_cls]  <= w_tot_inc;
        end
        if (i_cmd.rd) begin
            r_cell_q <= r_cell_mem[w_mem_addr];
            r_tot_q  <= r_class_mem[w_mem_cls];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.clr_step) begin
            r_sweep <= w_sweep_last ? '0 : r_sweep + AW'(1);
        end
    end

    // Saturate wide counters to the 32-bit result
    generate
        if (COUNT_WIDTH > 32) begin : g_wide
            assign w_cell32 = (|r_cell_q[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : r_cell_q[31:0];
            assign w_tot32  = (|r_tot_q[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : r_tot_q[31:0];
        end else begin : g_narrow
            assign w_cell32 = 32'(r_cell_q);
            assign w_tot32  = 32'(r_tot_q);
        end
    endgenerate

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cell    <= ((r_action == sph_pkg::ACT_READ) && w_renv_ok && w_rc_ok)
                           ? w_cell32 : 32'd0;
            r_out_total   <= ((r_action == sph_pkg::ACT_READ) && w_renv_ok) ? w_tot32 : 32'd0;
            r_out_outcome <= (r_action == sph_pkg::ACT_COUNT) ? w_count_outcome
                                                             : sph_pkg::OC_DONE;
        end
    end

    assign o_sts.action     = r_action;
    assign o_sts.do_first   = (r_action == sph_pkg::ACT_COUNT) && !w_gap && !w_mism && w_e1_ok;
    assign o_sts.do_second  = o_sts.do_first && w_e2_ok;
    assign o_sts.sweep_last = w_sweep_last;
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_cell    = r_out_cell;
    assign o_out_total   = r_out_total;
    assign o_out_outcome = r_out_outcome;

endmodule

`default_nettype wire

### rtl/substitution_pair_histogram_unit.sv
// Top level of the substitution pair histogram unit: controller, datapath and assertions.
`default_nettype none

// Counts environment-specific residue substitutions, one aligned column per input beat,
// into NUM_CLASSES x NUM_RESIDUES x NUM_RESIDUES saturating counters plus one total per
// class, all held in a single-port counter store. s_axis_tuser carries the action (count,
// read, clear). A counted column increments its first cell and then, when the second
// environment has a class, its second; one beat is in flight at a time. Each increment
// is a read then a write-back on the one store port. A clear beat sweeps the whole
// store, one entry a cycle. After reset the same sweep runs with s_axis_tready low;
// configuration writes are taken at any time, but should only be issued while no
// beat is in flight. The result sits in an output register, so a new beat is accepted
// while the previous result still waits for m_axis_tready; the next result is held until
// that slot drains. Every input beat gives exactly one output beat.
module substitution_pair_histogram_unit #(
    parameter int NUM_CLASSES  = sph_pkg::NUM_CLASSES_DEF,
    parameter int NUM_RESIDUES = sph_pkg::NUM_RESIDUES_DEF,
    parameter int COUNT_WIDTH  = sph_pkg::COUNT_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // slave side
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata, low to high: aa_first[4:0], aa_second[9:5], env_first[14:10],
    // env_second[19:15], features_first[51:20], features_second[83:52],
    // feature_present[87:84], read_env[91:88], read_row[96:92], read_col[101:97], zero pad
    input  wire  [sph_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: action[1:0]
    input  wire  [sph_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // master side
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata, low to high: cell_count[31:0], class_total[63:32]
    output logic [sph_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: outcome[2:0]
    output logic [sph_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    // configuration: active_constraints
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sph_pkg::CFG_W-1:0]        i_cfg_data
);

    sph_pkg::t_cmd w_cmd;
    sph_pkg::t_sts w_sts;
    logic [31:0]   w_out_cell;
    logic [31:0]   w_out_total;

    // The register is a plain flop, so every write beat is taken at once
    assign o_cfg_ready = 1'b1;

    sph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sph_dpath #(
        .NUM_CLASSES  (NUM_CLASSES),
        .NUM_RESIDUES (NUM_RESIDUES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_cell    (w_out_cell),
        .o_out_total   (w_out_total),
        .o_out_outcome (m_axis_tuser)
    );

    assign m_axis_tdata = {w_out_total, w_out_cell};

    // One beat in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a beat is still in flight");

    // Only read results carry data; count outcomes return zeros
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != sph_pkg::OC_DONE)) |-> (m_axis_tdata == '0))
        else $error("count outcome carries nonzero data");

    // The single store port does one thing per cycle
    a_one_store_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.rd, w_cmd.wr, w_cmd.clr_step}))
        else $error("conflicting counter store operations");

    // A loaded result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_cmd.load_out)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### verif/substitution_pair_histogram_unit_tb.sv
// Self-checking testbench for the substitution pair histogram unit: directed table plus random columns.
`timescale 1ns / 1ps

module substitution_pair_histogram_unit_tb;

    localparam int CLASS_CNT = sph_pkg::NUM_CLASSES_DEF;
    localparam int RES_CNT   = sph_pkg::NUM_RESIDUES_DEF;

    // Action 3 has no name in the package; the block answers it like a read of nothing
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // Six random segments of about 158 columns each, roughly 950 in all
    localparam int SEG_COUNT = 6;
    localparam int SEG_ITEMS = 158;

    // Longest quiet stretch of a correct run is one store sweep, after a clear beat or
    // after reset; the hold-off and random stalls are far shorter.
    localparam int QUIET_LIMIT = 50000;

    // Settle time after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES = 8;
    localparam int FINAL_CYCLES  = 20;

    // Receiver hold-off length, long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;

    // One input column, laid out as the block's tdata plus the tuser action
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  rcol;
        logic [4:0]  rrow;
        logic [3:0]  renv;
        logic [3:0]  present;
        logic [31:0] feat2;
        logic [31:0] feat1;
        logic [4:0]  env2;
        logic [4:0]  env1;
        logic [4:0]  aa2;
        logic [4:0]  aa1;
    } column_t;

    typedef struct packed {
        logic [31:0] cell_count;
        logic [31:0] class_total;
        logic [2:0]  outcome;
    } result_t;

    typedef struct {
        int      cfg;       // register value to write before the beat, -1 for none
        column_t col;
        bit      typed;     // result below is the answer, not the histogram model's
        result_t res;
    } stim_row_t;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sph_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [sph_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [sph_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [sph_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [sph_pkg::CFG_W-1:0]       i_cfg_data;

    // Histogram model state, updated as beats are accepted
    logic [31:0] pair_counts [CLASS_CNT][RES_CNT][RES_CNT];
    logic [31:0] class_sums  [CLASS_CNT];
    logic [2:0]  active_cfg;

    result_t   pending_results[$];
    stim_row_t stim_rows[$];

    int  mismatch_count;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    substitution_pair_histogram_unit #(
        .NUM_CLASSES  (CLASS_CNT),
        .NUM_RESIDUES (RES_CNT),
        .COUNT_WIDTH  (sph_pkg::COUNT_WIDTH_DEF)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata, low to high: aa_first, aa_second, env_first, env_second, features_first,
        // features_second, feature_present, read_env, read_row, read_col, zero pad
        .s_axis_tdata  (s_axis_tdata),
        // tuser: action
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata, low to high: cell_count, class_total
        .m_axis_tdata  (m_axis_tdata),
        // tuser: outcome
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Histogram model
    // ------------------------------------------------------------------

    function automatic void zero_histogram();
        for (int e = 0; e < CLASS_CNT; e++) begin
            class_sums[e] = '0;
            for (int r = 0; r < RES_CNT; r++)
                for (int c = 0; c < RES_CNT; c++)
                    pair_counts[e][r][c] = '0;
        end
    endfunction

    // Saturating bump of one cell and its class total
    function automatic void bump_pair(int env, int row, int col);
        if (pair_counts[env][row][col] != '1)
            pair_counts[env][row][col] = pair_counts[env][row][col] + 32'd1;
        if (class_sums[env] != '1)
            class_sums[env] = class_sums[env] + 32'd1;
    endfunction

    // An environment has a class only when its sign bit is clear and it is in range
    function automatic bit env_has_class(logic [4:0] env);
        return !env[4] && (int'(env[3:0]) < CLASS_CNT);
    endfunction

    function automatic result_t predict_histogram(column_t c);
        result_t r;
        int      n_slots;
        bit      differs;
        r = '0;
        r.outcome = sph_pkg::OC_DONE;
        case (c.action)
            sph_pkg::ACT_COUNT: begin
                // Compare only the active slots, capped at the slots carried
                n_slots = (int'(active_cfg) > sph_pkg::ACTIVE_LIMIT) ? sph_pkg::ACTIVE_LIMIT
                                                                     : int'(active_cfg);
                differs = 1'b0;
                for (int s = 0; s < n_slots; s++)
                    if (c.present[s] && (c.feat1[8*s +: 8] != c.feat2[8*s +: 8]))
                        differs = 1'b1;
                // Gap beats a constraint miss, which beats a missing class
                if (int'(c.aa1) >= RES_CNT || int'(c.aa2) >= RES_CNT) begin
                    r.outcome = sph_pkg::OC_GAP;
                end else if (differs) begin
                    r.outcome = sph_pkg::OC_CONSTRAINT;
                end else if (!env_has_class(c.env1)) begin
                    r.outcome = sph_pkg::OC_NO_CLASS;
                end else begin
                    bump_pair(int'(c.env1[3:0]), int'(c.aa2), int'(c.aa1));
                    r.outcome = sph_pkg::OC_ONE;
                    if (env_has_class(c.env2)) begin
                        bump_pair(int'(c.env2[3:0]), int'(c.aa1), int'(c.aa2));
                        r.outcome = sph_pkg::OC_BOTH;
                    end
                end
            end
            sph_pkg::ACT_READ: begin
                // Row or column out of range still returns the class total
                if (int'(c.renv) < CLASS_CNT) begin
                    r.class_total = class_sums[c.renv];
                    if (int'(c.rrow) < RES_CNT && int'(c.rcol) < RES_CNT)
                        r.cell_count = pair_counts[c.renv][c.rrow][c.rcol];
                end
            end
            sph_pkg::ACT_CLEAR: zero_histogram();
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic column_t mk_col(logic [1:0] action, int aa1, int aa2,
                                       int env1, int env2,
                                       logic [31:0] feat1, logic [31:0] feat2,
                                       int present, int renv,
                                       int rrow, int rcol);
        column_t c;
        c.action  = action;
        c.aa1     = 5'(aa1);
        c.aa2     = 5'(aa2);
        c.env1    = 5'(env1);
        c.env2    = 5'(env2);
        c.feat1   = feat1;
        c.feat2   = feat2;
        c.present = 4'(present);
        c.renv    = 4'(renv);
        c.rrow    = 5'(rrow);
        c.rcol    = 5'(rcol);
        return c;
    endfunction

    function automatic void add_row(int cfg, column_t c, bit typed, result_t r);
        stim_row_t row;
        row.cfg   = cfg;
        row.col   = c;
        row.typed = typed;
        row.res   = r;
        stim_rows.push_back(row);
    endfunction

    // Residues mostly from a small pool so cells fill up and reads hit them;
    // a few gaps and out-of-range codes
    function automatic logic [4:0] pick_residue();
        int k;
        k = $urandom_range(99);
        if (k < 45)
            return 5'($urandom_range(3));
        else if (k < 92)
            return 5'($urandom_range(RES_CNT - 1));
        else
            return 5'($urandom_range(31, RES_CNT));
    endfunction

    function automatic logic [4:0] pick_env(int valid_pct);
        if ($urandom_range(99) < valid_pct)
            return $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(15));
        else
            return 5'($urandom_range(31, 16));   // negative: no class
    endfunction

    function automatic column_t random_column();
        column_t c;
        int      k;
        int      slot;
        c = '0;
        k = $urandom_range(99);
        c.aa1     = pick_residue();
        c.aa2     = pick_residue();
        c.env1    = pick_env(85);
        c.env2    = pick_env(70);
        c.feat1   = $urandom;
        c.feat2   = c.feat1;
        c.present = 4'($urandom_range(15));
        // Most columns agree on every feature; break one slot now and then
        if ($urandom_range(99) < 25) begin
            slot = $urandom_range(3);
            c.feat2[8*slot +: 8] = c.feat2[8*slot +: 8] ^ 8'($urandom_range(255, 1));
        end
        c.renv = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        c.rrow = pick_residue();
        c.rcol = pick_residue();
        if (k < 72)
            c.action = sph_pkg::ACT_COUNT;
        else if (k < 94)
            c.action = sph_pkg::ACT_READ;
        else
            c.action = ACT_SPARE;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one beat after a random gap; hold it until accepted, then queue its result
    task automatic drive_beat(input column_t c, input bit typed, input result_t typed_res);
        result_t pred;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.action;
        s_axis_tdata  <= {2'b00, c.rcol, c.rrow, c.renv, c.present, c.feat2, c.feat1,
                          c.env2, c.env1, c.aa2, c.aa1};
        do @(posedge i_clk); while (!s_axis_tready);
        // Run the model on every beat so its state tracks, even on typed rows
        pred = predict_histogram(c);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // Stop offering, wait out every pending result, then let the block settle
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        active_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Receiver: check the beat taken at this edge, then pick next cycle's ready
    always @(posedge i_clk) begin : result_sink
        result_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending, outcome",
                                32'(m_axis_tuser), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] != want.cell_count)
                    report_mismatch("cell_count", m_axis_tdata[31:0], want.cell_count);
                if (m_axis_tdata[63:32] != want.class_total)
                    report_mismatch("class_total", m_axis_tdata[63:32], want.class_total);
                if (m_axis_tuser != want.outcome)
                    report_mismatch("outcome", 32'(m_axis_tuser), 32'(want.outcome));
            end
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            // Start a long hold-off; the sender keeps pushing so the block backs up
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: end the run after too long with no beat on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        int seg_cfg [SEG_COUNT];
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= sph_pkg::ACT_COUNT;
        m_axis_tready  <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        i_rst_n        <= 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        active_cfg     = '0;
        snd_idle_pct   = 35;
        rcv_idle_pct   = 81;
        zero_histogram();

        // Directed table. Typed answers where they are plain: empty store after reset,
        // skips, unused action, clear. Counts and reads of counted cells go to the model.
        // Register stays at its reset value of zero until the first write below.
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 15, 21, 21),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});
        // Gap code on either side, and an out-of-range residue counts as a gap
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 22, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_GAP});
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_GAP});
        // First environment negative: -1 and the most negative value
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 0, 0, 31, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_NO_CLASS});
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 0, 0, 16, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_NO_CLASS});
        // No slots compared: features that differ everywhere still count
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 0, 21, 0, 31, 32'h0, 32'hFFFF_FFFF, 15,
                           0, 0, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 21, 0, 15, 15, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 21, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 15, 0, 21), 1'b0, '0);
        // All four slots compared
        add_row(4, mk_col(sph_pkg::ACT_COUNT, 1, 2, 3, 4, 32'hFFFF_FFFF, 32'hFFFF_FF00, 1,
                          0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_CONSTRAINT});
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 1, 2, 3, 4, 32'h1234_5678, 32'h0234_5678, 8,
                           0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_CONSTRAINT});
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 1, 2, 3, 31, 32'h1234_5678, 32'h0234_5678, 7,
                           0, 0, 0), 1'b0, '0);
        // Register above the slot count is capped at four slots
        add_row(7, mk_col(sph_pkg::ACT_COUNT, 1, 2, 3, 4, 32'h1234_5678, 32'h0234_5678, 8,
                          0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_CONSTRAINT});
        // One slot compared: differences past slot 0, or in an absent slot, pass
        add_row(1, mk_col(sph_pkg::ACT_COUNT, 2, 1, 4, 3, 32'h0000_AA00, 32'h0000_5500, 15,
                          0, 0, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 2, 1, 4, 3, 32'h0000_00AA, 32'h0000_0055, 14,
                           0, 0, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 2, 1, 4, 3, 32'h0000_00AA, 32'h0000_0055, 1,
                           0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_CONSTRAINT});
        // Gap wins over a constraint miss; a constraint miss wins over no class
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 22, 1, 4, 3, 32'h0000_00AA, 32'h0000_0055, 1,
                           0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_GAP});
        add_row(-1, mk_col(sph_pkg::ACT_COUNT, 2, 1, 31, 3, 32'h0000_00AA, 32'h0000_0055, 1,
                           0, 0, 0), 1'b1, '{32'd0, 32'd0, sph_pkg::OC_CONSTRAINT});
        // Row out of range: cell reads zero but the class total still comes back
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 3, 31, 0), 1'b0, '0);
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 4, 1, 2), 1'b0, '0);
        add_row(-1, mk_col(ACT_SPARE, 0, 0, 0, 0, 0, 0, 0, 4, 1, 2),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});
        add_row(-1, mk_col(sph_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 21, 0),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});
        add_row(-1, mk_col(sph_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 15, 0, 21),
                1'b1, '{32'd0, 32'd0, sph_pkg::OC_DONE});

        // Register setting per random segment: extremes, the capped values, a few between
        seg_cfg = '{4, 1, 7, 2, 0, 3};

        // Hold reset, then release; the block runs its clearing sweep before taking beats
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].cfg >= 0) begin
                drain(SETTLE_CYCLES);
                write_cfg(3'(stim_rows[i].cfg));
            end
            drive_beat(stim_rows[i].col, stim_rows[i].typed, stim_rows[i].res);
        end

        // Random segments: two with a slow receiver, two with a slow sender, two flat out
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            drain(SETTLE_CYCLES);
            write_cfg(3'(seg_cfg[seg]));
            snd_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 81 : 0;
            rcv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 35 : 0;
            if (seg == 4)
                hold_req = 1'b1;
            for (int i = 0; i < SEG_ITEMS; i++) begin
                // One clear per even segment keeps sweep time bounded; on odd segments
                // pause the sender until the block has answered everything
                if (i == SEG_ITEMS / 2) begin
                    if (seg % 2 == 0)
                        drive_beat(mk_col(sph_pkg::ACT_CLEAR, $urandom_range(31),
                                          $urandom_range(31), $urandom_range(31),
                                          $urandom_range(31), $urandom, $urandom,
                                          $urandom_range(15), $urandom_range(15),
                                          $urandom_range(31), $urandom_range(31)),
                                   1'b0, '0);
                    else
                        drain(0);
                end
                drive_beat(random_column(), 1'b0, '0);
            end
        end

        drain(FINAL_CYCLES);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
